// ----- design/rpcr_pkg.sv -----
// Package for the remote pulse code receiver.
// Holds field widths, register reset values, register indexes and the window hit struct.
// No dependencies.
package rpcr_pkg;

  localparam int CFG_W      = 16;
  localparam int ELAPSED_W  = 16;
  localparam int CODE_W     = 24;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam int DEF_CODE_BITS       = 24;
  localparam int DEF_SYNC_LOW_FACTOR = 32;
  localparam int LONG_FACTOR         = 3;

  localparam logic [CFG_W-1:0] WIDTH_MIN_RST = 16'd100;
  localparam logic [CFG_W-1:0] WIDTH_MAX_RST = 16'd1000;

  localparam logic REG_WIDTH_MIN = 1'b0;
  localparam logic REG_WIDTH_MAX = 1'b1;

  typedef struct packed {
    logic hit_short;
    logic hit_long;
    logic hit_sync;
  } rpcr_win_t;

endpackage

// ----- design/rpcr_window.sv -----
// Pulse width classifier: tests one elapsed time against the 1, 3 and sync-length windows.
// Depends on rpcr_pkg.
module rpcr_window import rpcr_pkg::*; #(
  parameter int SYNC_LOW_FACTOR = DEF_SYNC_LOW_FACTOR
) (
  input  logic [CFG_W-1:0]     width_min_i,
  input  logic [CFG_W-1:0]     width_max_i,
  input  logic [ELAPSED_W-1:0] elapsed_i,
  output rpcr_win_t            win_o
);

  localparam int PW = CFG_W + $clog2(SYNC_LOW_FACTOR + 1);

  logic [PW-1:0] t_ext;
  logic [PW-1:0] min_1, max_1;
  logic [PW-1:0] min_3, max_3;
  logic [PW-1:0] min_s, max_s;

  always_comb begin
    t_ext = PW'(elapsed_i);
    min_1 = PW'(width_min_i);
    max_1 = PW'(width_max_i);
    min_3 = min_1 * PW'(LONG_FACTOR);
    max_3 = max_1 * PW'(LONG_FACTOR);
    min_s = min_1 * PW'(SYNC_LOW_FACTOR);
    max_s = max_1 * PW'(SYNC_LOW_FACTOR);
    win_o.hit_short = (min_1 < t_ext) && (t_ext < max_1);
    win_o.hit_long  = (min_3 < t_ext) && (t_ext < max_3);
    win_o.hit_sync  = (min_s < t_ext) && (t_ext < max_s);
  end

endmodule

// ----- design/rpcr_decoder.sv -----
// Frame decoder: phase state machine, code shift register, bit count and result register.
// Depends on rpcr_pkg and the window hits from rpcr_window.
module rpcr_decoder import rpcr_pkg::*; #(
  parameter int CODE_BITS = DEF_CODE_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic              level_i,
  input  rpcr_win_t         win_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [CODE_W-1:0] code_o
);

  localparam int CW = $clog2(CODE_BITS + 1);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SYNC_H = 3'd1,
    PH_SYNC_L = 3'd2,
    PH_DATA_H = 3'd3,
    PH_DATA_0 = 3'd4,
    PH_DATA_1 = 3'd5
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [CODE_W-1:0] shift_q, shift_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     count_inc;
  logic              took;
  logic              emit;
  logic              out_valid_q, out_valid_d;
  logic [CODE_W-1:0] code_q, code_d;

  always_comb begin
    phase_d   = phase_q;
    shift_d   = shift_q;
    count_d   = count_q;
    took      = 1'b0;
    count_inc = count_q + 1'b1;
    if (fire_i) begin
      unique case (phase_q)
        PH_SYNC_H: begin
          if (!level_i) begin
            phase_d = win_i.hit_short ? PH_SYNC_L : PH_IDLE;
          end
        end
        PH_SYNC_L: begin
          if (!level_i) begin
            phase_d = PH_IDLE;
          end else if (win_i.hit_sync) begin
            shift_d = '0;
            count_d = '0;
            phase_d = PH_DATA_H;
          end else begin
            phase_d = PH_SYNC_H;
          end
        end
        PH_DATA_H: begin
          if (level_i) begin
            phase_d = PH_IDLE;
          end else if (win_i.hit_short) begin
            phase_d = PH_DATA_0;
          end else if (win_i.hit_long) begin
            phase_d = PH_DATA_1;
          end else begin
            phase_d = PH_IDLE;
          end
        end
        PH_DATA_0: begin
          if (!level_i) begin
            phase_d = PH_IDLE;
          end else if (win_i.hit_long) begin
            shift_d = {shift_q[CODE_W-2:0], 1'b0};
            count_d = count_inc;
            took    = 1'b1;
            phase_d = PH_DATA_H;
          end else if (win_i.hit_sync) begin
            shift_d = '0;
            count_d = '0;
            phase_d = PH_DATA_H;
          end else begin
            phase_d = PH_SYNC_H;
          end
        end
        PH_DATA_1: begin
          if (!level_i) begin
            phase_d = PH_IDLE;
          end else if (win_i.hit_short) begin
            shift_d = {shift_q[CODE_W-2:0], 1'b1};
            count_d = count_inc;
            took    = 1'b1;
            phase_d = PH_DATA_H;
          end else begin
            phase_d = PH_SYNC_H;
          end
        end
        default: begin
          phase_d = level_i ? PH_SYNC_H : PH_IDLE;
        end
      endcase
    end
    emit = took && (count_inc >= CW'(CODE_BITS));
    if (emit) begin
      phase_d = PH_SYNC_H;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    code_d      = code_q;
    if (emit) begin
      out_valid_d = 1'b1;
      code_d      = shift_d;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      shift_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      shift_q     <= shift_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

  assign out_valid_o = out_valid_q;
  assign code_o      = code_q;

endmodule

// ----- design/remote_pulse_code_receiver.sv -----
// Remote pulse code receiver top level: APB registers, edge input register, decoder.
// The edge that completes a code passes the input register, then the result register.
// Throughput: one edge per cycle while no result is stalled in the output register.
// A waiting result stalls the decoder; the input register can still take one item meanwhile.
// Reset (asynchronous, active low) sets the phase to idle, clears the bit count and code
// shift register, empties both registers and loads width_min 100 and width_max 1000.
module remote_pulse_code_receiver import rpcr_pkg::*; #(
  parameter int CODE_BITS       = DEF_CODE_BITS,
  parameter int SYNC_LOW_FACTOR = DEF_SYNC_LOW_FACTOR
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  level_i,
  input  logic [ELAPSED_W-1:0]  elapsed_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CODE_W-1:0]     code_o
);

  logic [CFG_W-1:0]     width_min_q, width_max_q;
  logic                 cfg_wr;
  logic                 in_valid_q;
  logic                 level_q;
  logic [ELAPSED_W-1:0] elapsed_q;
  logic                 advance;
  logic                 fire;
  rpcr_win_t            win;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_min_q <= WIDTH_MIN_RST;
      width_max_q <= WIDTH_MAX_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WIDTH_MIN: width_min_q <= pwdata[CFG_W-1:0];
        REG_WIDTH_MAX: width_max_q <= pwdata[CFG_W-1:0];
        default:       width_min_q <= width_min_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH_MIN: prdata = APB_DATA_W'(width_min_q);
      REG_WIDTH_MAX: prdata = APB_DATA_W'(width_max_q);
      default:       prdata = '0;
    endcase
  end

  assign advance    = !out_valid_o || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      level_q   <= level_i;
      elapsed_q <= elapsed_i;
    end
  end

  rpcr_window #(
    .SYNC_LOW_FACTOR(SYNC_LOW_FACTOR)
  ) u_window (
    .width_min_i(width_min_q),
    .width_max_i(width_max_q),
    .elapsed_i  (elapsed_q),
    .win_o      (win)
  );

  rpcr_decoder #(
    .CODE_BITS(CODE_BITS)
  ) u_decoder (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .level_i    (level_q),
    .win_i      (win),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .code_o     (code_o)
  );

  a_held_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(level_q) && $stable(elapsed_q)))
    else $error("Held input item was lost or changed while the result was stalled.");

  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(fire))
    else $error("A result appeared without an item being decoded.");

  a_cfg_min_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && (paddr[2] == REG_WIDTH_MIN)) |=> (width_min_q == $past(pwdata[CFG_W-1:0])))
    else $error("width_min register did not take the written value.");

endmodule

// ----- sim/remote_pulse_code_receiver_test.sv -----
// Self-checking testbench for the remote pulse code receiver.
// Predicts decoded codes from the edge stream and the width registers set over APB.
// Depends on rpcr_pkg and remote_pulse_code_receiver.
module remote_pulse_code_receiver_test;
  import rpcr_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int ITEM_TARGET = 1650;
  localparam int CODE_TARGET = 40;

  typedef enum logic [2:0] {
    PH_IDLE, PH_SYNC_HIGH, PH_SYNC_LOW, PH_DATA_HIGH, PH_DATA_LOW0, PH_DATA_LOW1
  } rx_phase_e;

  typedef enum int {FRAME_CLEAN, FRAME_GLITCH, FRAME_RESTART} frame_kind_e;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic                  level_i     = 1'b0;
  logic [ELAPSED_W-1:0]  elapsed_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [CODE_W-1:0]     code_o;

  remote_pulse_code_receiver u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .level_i     (level_i),
    .elapsed_i   (elapsed_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .code_o      (code_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  logic [CFG_W-1:0]  cfg_min = WIDTH_MIN_RST;
  logic [CFG_W-1:0]  cfg_max = WIDTH_MAX_RST;
  rx_phase_e         rx_phase = PH_IDLE;
  logic [CODE_W-1:0] rx_code = '0;
  int                rx_count = 0;
  logic [CODE_W-1:0] expected_codes[$];

  int error_count     = 0;
  int items_sent      = 0;
  int codes_predicted = 0;
  int codes_checked   = 0;
  int settings_used   = 1;
  int cycle_count     = 0;
  int stall_left      = 0;
  int glitch_at       = -1;
  int edge_idx        = 0;
  bit allow_idle      = 1'b1;
  bit send_idle_on    = 1'b1;
  bit recv_idle_on    = 1'b1;
  logic [CODE_W-1:0] want_code;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h", what, got, want);
    error_count++;
  endtask

  function automatic bit in_band(input logic [ELAPSED_W-1:0] t, input int unsigned k);
    return (32'(cfg_min) * k < 32'(t)) && (32'(t) < 32'(cfg_max) * k);
  endfunction

  function automatic void decode_edge(input bit lvl, input logic [ELAPSED_W-1:0] t);
    bit got_bit;
    bit bit_val;
    got_bit = 1'b0;
    bit_val = 1'b0;
    case (rx_phase)
      PH_SYNC_HIGH: begin
        if (!lvl) rx_phase = in_band(t, 1) ? PH_SYNC_LOW : PH_IDLE;
      end
      PH_SYNC_LOW: begin
        if (!lvl) begin
          rx_phase = PH_IDLE;
        end else if (in_band(t, DEF_SYNC_LOW_FACTOR)) begin
          rx_code  = '0;
          rx_count = 0;
          rx_phase = PH_DATA_HIGH;
        end else begin
          rx_phase = PH_SYNC_HIGH;
        end
      end
      PH_DATA_HIGH: begin
        if (lvl) rx_phase = PH_IDLE;
        else if (in_band(t, 1)) rx_phase = PH_DATA_LOW0;
        else if (in_band(t, LONG_FACTOR)) rx_phase = PH_DATA_LOW1;
        else rx_phase = PH_IDLE;
      end
      PH_DATA_LOW0: begin
        if (!lvl) begin
          rx_phase = PH_IDLE;
        end else if (in_band(t, LONG_FACTOR)) begin
          got_bit = 1'b1;
        end else if (in_band(t, DEF_SYNC_LOW_FACTOR)) begin
          rx_code  = '0;
          rx_count = 0;
          rx_phase = PH_DATA_HIGH;
        end else begin
          rx_phase = PH_SYNC_HIGH;
        end
      end
      PH_DATA_LOW1: begin
        if (!lvl) begin
          rx_phase = PH_IDLE;
        end else if (in_band(t, 1)) begin
          got_bit = 1'b1;
          bit_val = 1'b1;
        end else begin
          rx_phase = PH_SYNC_HIGH;
        end
      end
      default: begin
        rx_phase = lvl ? PH_SYNC_HIGH : PH_IDLE;
      end
    endcase
    if (got_bit) begin
      rx_code  = {rx_code[CODE_W-2:0], bit_val};
      rx_count++;
      rx_phase = PH_DATA_HIGH;
      if (rx_count >= DEF_CODE_BITS) begin
        expected_codes.push_back(rx_code);
        codes_predicted++;
        rx_phase = PH_SYNC_HIGH;
      end
    end
  endfunction

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d codes outstanding.",
               cycle_count, expected_codes.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (rst_ni && recv_idle_on && $urandom_range(0, 9) == 0) begin
      stall_left  <= $urandom_range(1, 12) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_codes.size() == 0) begin
        report_mismatch("code with none expected", 32'(code_o), 32'h0);
      end else begin
        want_code = expected_codes.pop_front();
        if (code_o !== want_code) report_mismatch("code", 32'(code_o), 32'(want_code));
        codes_checked++;
      end
    end
  end

  task automatic send_edge(input bit lvl, input logic [ELAPSED_W-1:0] t);
    if (send_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    level_i    <= lvl;
    elapsed_i  <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    decode_edge(lvl, t);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_codes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input logic reg_idx,
                            input logic [CFG_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {{(APB_DATA_W-CFG_W){1'b0}}, wdata};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_width_reg(input logic reg_idx);
    logic [APB_DATA_W-1:0] rdata;
    apb_access(1'b0, reg_idx, '0, rdata);
    if (reg_idx == REG_WIDTH_MIN) begin
      if (rdata !== 32'(cfg_min)) report_mismatch("width_min readback", rdata, 32'(cfg_min));
    end else begin
      if (rdata !== 32'(cfg_max)) report_mismatch("width_max readback", rdata, 32'(cfg_max));
    end
  endtask

  task automatic write_width_reg(input logic reg_idx, input logic [CFG_W-1:0] value);
    logic [APB_DATA_W-1:0] rdata;
    apb_access(1'b1, reg_idx, value, rdata);
    if (reg_idx == REG_WIDTH_MIN) cfg_min = value;
    else cfg_max = value;
    check_width_reg(reg_idx);
  endtask

  task automatic set_widths(input logic [CFG_W-1:0] wmin, input logic [CFG_W-1:0] wmax);
    wait_drained();
    write_width_reg(REG_WIDTH_MIN, wmin);
    write_width_reg(REG_WIDTH_MAX, wmax);
    settings_used++;
  endtask

  // Tolerance bands of 70-90 and 110-130 percent keep the short and long windows apart.
  task automatic set_random_widths();
    int unsigned base;
    base = $urandom_range(40, 1600);
    set_widths(CFG_W'(base * $urandom_range(70, 90) / 100),
               CFG_W'(base * $urandom_range(110, 130) / 100));
  endtask

  function automatic logic [ELAPSED_W-1:0] pick_width(input int unsigned k);
    logic [31:0] lo;
    logic [31:0] hi;
    lo = 32'(cfg_min) * k + 1;
    hi = 32'(cfg_max) * k;
    if (hi == 0) return ELAPSED_W'($urandom_range(0, 65535));
    hi = hi - 1;
    if (hi > 65535) hi = 65535;
    if (lo > hi) return ELAPSED_W'($urandom_range(0, 65535));
    return ELAPSED_W'($urandom_range(lo, hi));
  endfunction

  task automatic send_frame_edge(input bit lvl, input logic [ELAPSED_W-1:0] t);
    bit                   l;
    logic [ELAPSED_W-1:0] w;
    l = lvl;
    w = t;
    if (edge_idx == glitch_at) begin
      if ($urandom_range(0, 1) == 1) l = !l;
      else w = ELAPSED_W'($urandom_range(0, 65535));
    end
    edge_idx++;
    send_edge(l, w);
  endtask

  task automatic send_frame(input logic [CODE_W-1:0] code, input frame_kind_e kind);
    int restart_at;
    restart_at = (kind == FRAME_RESTART) ? $urandom_range(1, CODE_W - 1) : -1;
    glitch_at  = (kind == FRAME_GLITCH) ? $urandom_range(0, 2 * CODE_W + 2) : -1;
    edge_idx   = 0;
    send_frame_edge(1'b1, ELAPSED_W'($urandom_range(0, 65535)));
    send_frame_edge(1'b0, pick_width(1));
    send_frame_edge(1'b1, pick_width(DEF_SYNC_LOW_FACTOR));
    for (int i = CODE_W - 1; i >= 0; i--) begin
      if (CODE_W - 1 - i == restart_at) begin
        send_frame_edge(1'b0, pick_width(1));
        send_frame_edge(1'b1, pick_width(DEF_SYNC_LOW_FACTOR));
      end
      if (code[i]) begin
        send_frame_edge(1'b0, pick_width(LONG_FACTOR));
        send_frame_edge(1'b1, pick_width(1));
      end else begin
        send_frame_edge(1'b0, pick_width(1));
        send_frame_edge(1'b1, pick_width(LONG_FACTOR));
      end
    end
  endtask

  function automatic logic [CODE_W-1:0] random_code();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return CODE_W'($urandom());
    endcase
  endfunction

  task automatic traffic_step();
    int pick;
    pick = $urandom_range(0, 9);
    send_idle_on = allow_idle && ($urandom_range(0, 3) != 0);
    recv_idle_on = allow_idle && ($urandom_range(0, 3) != 0);
    if (pick <= 6) begin
      send_frame(random_code(), FRAME_CLEAN);
    end else if (pick == 7) begin
      send_frame(random_code(), FRAME_GLITCH);
    end else if (pick == 8) begin
      send_frame(random_code(), FRAME_RESTART);
    end else begin
      repeat ($urandom_range(1, 20)) begin
        if ($urandom_range(0, 1) == 1)
          send_edge(1'($urandom_range(0, 1)), ELAPSED_W'($urandom_range(0, 65535)));
        else
          send_edge(1'($urandom_range(0, 1)), pick_width($urandom_range(1, 40)));
      end
    end
  endtask

  task automatic test_reset_values();
    check_width_reg(REG_WIDTH_MIN);
    check_width_reg(REG_WIDTH_MAX);
  endtask

  // Reset widths 100 and 1000 are in force: the base window is 100..1000 exclusive.
  task automatic test_special_cases();
    send_edge(1'b0, 16'd500);
    send_edge(1'b1, 16'd65535);
    send_edge(1'b1, 16'd0);
    send_edge(1'b0, 16'd65535);
    send_edge(1'b1, 16'd0);
    send_edge(1'b0, 16'd100);
    send_edge(1'b1, 16'd0);
    send_edge(1'b0, 16'd101);
    send_edge(1'b0, 16'd16000);
    send_edge(1'b1, 16'd0);
    send_edge(1'b0, 16'd999);
    send_edge(1'b1, 16'd3200);
    send_edge(1'b0, 16'd500);
    send_edge(1'b1, 16'd31999);
    send_edge(1'b1, 16'd500);
    send_edge(1'b1, 16'd0);
    send_edge(1'b0, 16'd500);
    send_edge(1'b1, 16'd16000);
    send_edge(1'b0, 16'd1000);
    send_edge(1'b0, 16'd500);
    send_edge(1'b1, 16'd0);
    send_edge(1'b0, 16'd500);
    send_edge(1'b1, 16'd16000);
    send_edge(1'b0, 16'd500);
    send_edge(1'b1, 16'd16000);
    send_edge(1'b0, 16'd3000);
  endtask

  task automatic test_register_extremes();
    set_widths(16'd0, 16'd65535);
    send_frame(random_code(), FRAME_CLEAN);
    send_frame(random_code(), FRAME_CLEAN);
    set_widths(16'd65535, 16'd0);
    send_frame(random_code(), FRAME_CLEAN);
    set_widths(16'd700, 16'd700);
    send_frame(random_code(), FRAME_CLEAN);
    set_widths(16'd1, 16'd2047);
    send_frame(random_code(), FRAME_CLEAN);
  endtask

  task automatic test_random_frames();
    int start;
    for (int s = 0; s < 4; s++) begin
      set_random_widths();
      start = items_sent;
      while (items_sent - start < 225) traffic_step();
    end
  endtask

  task automatic test_drain_pause();
    set_random_widths();
    for (int i = 0; i < 4; i++) begin
      send_frame(random_code(), FRAME_CLEAN);
      wait_drained();
    end
  endtask

  task automatic test_no_idle();
    int start;
    allow_idle = 1'b0;
    set_random_widths();
    start = items_sent;
    while (items_sent - start < 150 || items_sent < ITEM_TARGET ||
           codes_predicted < CODE_TARGET) traffic_step();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_special_cases();
    test_register_extremes();
    test_random_frames();
    test_drain_pause();
    test_no_idle();
    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d edges under %0d width settings; %0d decoded codes checked.",
             items_sent, settings_used, codes_checked);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches found.", error_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- remote_pulse_code_receiver.f -----
design/rpcr_pkg.sv
design/rpcr_window.sv
design/rpcr_decoder.sv
design/remote_pulse_code_receiver.sv
sim/remote_pulse_code_receiver_test.sv
